/* hw/rtl/mada_pkg.sv */
// Shared types, opcodes and stream bit positions for the misaligned access decode block.
package mada_pkg;

	// Major opcodes and field masks
	localparam logic [6:0] OP_LOAD     = 7'h03;
	localparam logic [6:0] OP_STORE    = 7'h23;
	localparam logic [6:0] OP_LOAD_FP  = 7'h07;
	localparam logic [6:0] OP_STORE_FP = 7'h27;
	localparam logic [6:0] OPC_MASK    = 7'h7f;
	localparam logic [4:0] REG_MASK    = 5'h1f;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_XLEN_IS_64 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_F_PRESENT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_D_PRESENT  = 2'd2;

	// Input word layout (lowest bit first)
	localparam int IN_INSTR_LSB = 0;
	localparam int IN_TST_BIT   = 32;
	localparam int IN_FSON_BIT  = 33;
	localparam int IN_LB_LSB    = 34;
	localparam int IN_SRC_LSB   = 98;
	localparam int IN_USED_W    = 162;
	localparam int IN_W         = 168;

	// Output word layout (lowest bit first)
	localparam int OUT_VERDICT_BIT = 0;
	localparam int OUT_ST_BIT      = 1;
	localparam int OUT_FP_BIT      = 2;
	localparam int OUT_LEN_LSB     = 3;
	localparam int OUT_REG_LSB     = 7;
	localparam int OUT_ILEN_LSB    = 12;
	localparam int OUT_LRES_LSB    = 15;
	localparam int OUT_WB_BIT      = 79;
	localparam int OUT_SDAT_LSB    = 80;
	localparam int OUT_FSD_BIT     = 144;
	localparam int OUT_USED_W      = 145;
	localparam int OUT_W           = 152;

	typedef struct packed {
		logic xlen_is_64;
		logic f_present;
		logic d_present;
	} mada_cfg_t;

	// Decoded access and the emulate/redirect decision
	typedef struct packed {
		logic       redirect;
		logic       st;
		logic       fp;
		logic       sext;
		logic [3:0] len;
		logic [4:0] rd;
		logic [2:0] ilen;
	} mada_dec_t;

	typedef struct packed {
		logic        verdict;
		logic        access_is_store;
		logic        access_is_fp;
		logic [3:0]  access_len;
		logic [4:0]  reg_index;
		logic [2:0]  instr_bytes;
		logic [63:0] load_result;
		logic        load_writeback;
		logic [63:0] store_data;
		logic        set_fs_dirty;
	} mada_res_t;

endpackage

/* hw/rtl/mada_decode.sv */
// Instruction decode and emulate/redirect decision.
module mada_decode (
	input  logic [31:0]        instruction,
	input  logic               trap_is_store,
	input  logic               fp_state_on,
	input  mada_pkg::mada_cfg_t cfg,
	output mada_pkg::mada_dec_t dec
);

	logic       ok;
	logic       st;
	logic       fp;
	logic       sext;
	logic [3:0] len;
	logic [4:0] rd;
	logic [2:0] ilen;
	logic [2:0] f3w;
	logic [2:0] f3c;
	logic [2:0] sub;
	logic       sp;
	logic [6:0] opc;

	assign f3w = instruction[14:12];
	assign f3c = instruction[15:13];
	assign sub = instruction[12:10];
	assign sp  = (instruction[1:0] == 2'd2);
	assign opc = instruction[6:0] & mada_pkg::OPC_MASK;

	always_comb begin
		ok   = 1'b0;
		st   = 1'b0;
		fp   = 1'b0;
		sext = 1'b0;
		len  = 4'd0;
		rd   = 5'd0;
		ilen = 3'd0;
		if (instruction[1:0] == 2'd3) begin
			ilen = 3'd4;
			unique case (opc)
				mada_pkg::OP_LOAD: begin
					len  = 4'd1 << f3w[1:0];
					sext = ~f3w[2];
					rd   = instruction[11:7];
					ok   = (f3w[1:0] != 2'd0);
				end
				mada_pkg::OP_STORE: begin
					st  = 1'b1;
					len = 4'd1 << f3w[1:0];
					rd  = instruction[24:20];
					ok  = ~f3w[2] && (f3w[1:0] != 2'd0);
				end
				mada_pkg::OP_LOAD_FP, mada_pkg::OP_STORE_FP: begin
					fp  = 1'b1;
					st  = (opc == mada_pkg::OP_STORE_FP);
					len = f3w[0] ? 4'd8 : 4'd4;
					rd  = st ? instruction[24:20] : instruction[11:7];
					ok  = (f3w == 3'd2) || (f3w == 3'd3);
				end
				default: ok = 1'b0;
			endcase
		end else if (instruction[1:0] != 2'd1) begin
			ilen = 3'd2;
			sext = 1'b1;
			st   = f3c[2] && (f3c != 3'd4);
			if (!sp)
				rd = {2'b01, instruction[4:2]};
			else if (st)
				rd = instruction[6:2];
			else
				rd = instruction[11:7];
			case (f3c)
				3'd2, 3'd6: begin
					len = 4'd4;
					ok  = 1'b1;
				end
				3'd3, 3'd7: begin
					len = cfg.xlen_is_64 ? 4'd8 : 4'd4;
					fp  = ~cfg.xlen_is_64;
					ok  = 1'b1;
				end
				3'd1, 3'd5: begin
					len = 4'd8;
					fp  = 1'b1;
					ok  = 1'b1;
				end
				3'd4: begin
					// Zcb halfword forms: c.lhu, c.lh, c.sh
					len  = 4'd2;
					st   = (sub == 3'd3);
					sext = instruction[6];
					rd   = {2'b01, instruction[4:2]};
					ok   = ~sp && ((sub == 3'd1) || (sub == 3'd3));
				end
				default: ok = 1'b0;
			endcase
			// stack-relative integer loads need a nonzero destination
			if (f3c != 3'd4 && !(fp || st || !sp || rd != 5'd0))
				ok = 1'b0;
		end
	end

	always_comb begin
		dec.redirect = ~ok || (st != trap_is_store) ||
			(fp && (~cfg.f_present || ~fp_state_on || (len == 4'd8 && ~cfg.d_present)));
		dec.st   = st;
		dec.fp   = fp;
		dec.sext = sext;
		dec.len  = len;
		dec.rd   = rd;
		dec.ilen = ilen;
	end

endmodule

/* hw/rtl/mada_align.sv */
// Load result assembly, store masking and final result fields.
module mada_align (
	input  mada_pkg::mada_dec_t dec,
	input  logic                xlen_is_64,
	input  logic [63:0]         load_bytes,
	input  logic [63:0]         store_source,
	output mada_pkg::mada_res_t res
);

	logic [63:0] lval;
	logic [63:0] sval;
	logic [63:0] src;

	always_comb begin
		case (dec.len)
			4'd2:    lval = {{48{dec.sext & ~dec.fp & load_bytes[15]}}, load_bytes[15:0]};
			4'd4:    lval = {{32{dec.sext & ~dec.fp & load_bytes[31]}}, load_bytes[31:0]};
			default: lval = load_bytes;
		endcase
		if (!dec.fp && !xlen_is_64)
			lval[63:32] = 32'd0;
	end

	always_comb begin
		src = store_source;
		if (!dec.fp && !xlen_is_64)
			src[63:32] = 32'd0;
		case (dec.len)
			4'd2:    sval = {48'd0, src[15:0]};
			4'd4:    sval = {32'd0, src[31:0]};
			default: sval = src;
		endcase
	end

	always_comb begin
		res = '0;
		res.verdict = dec.redirect;
		if (!dec.redirect) begin
			res.access_is_store = dec.st;
			res.access_is_fp    = dec.fp;
			res.access_len      = dec.len;
			res.reg_index       = dec.rd;
			res.instr_bytes     = dec.ilen;
			if (dec.st) begin
				res.store_data = sval;
			end else begin
				res.load_result    = lval;
				res.load_writeback = ~dec.fp && (dec.rd != 5'd0);
				res.set_fs_dirty   = dec.fp;
			end
		end
	end

endmodule

/* hw/rtl/misaligned_access_decode_align.sv */
// Top level: misaligned access decode and data alignment, two-register stream pipeline.
//
//  channel  | direction | word                              | accepted when
//  ---------+-----------+-----------------------------------+------------------------
//  s_*      | in        | trapped access (instr, bytes)     | s_tvalid & s_tready
//  m_*      | out       | verdict, decode, aligned data     | m_tvalid & m_tready
//  cfg_*    | in        | xlen / F / D enables              | cfg_we
//
// Each word is registered on entry (_s1), decoded and aligned by short logic, and the
// result registered (_s2): m_tvalid rises once the word has passed through both registers;
// one word per cycle sustained while m_tready stays high.
// A stalled output holds its word while the input register can still take the next one;
// s_tready is low only when both registers are full and m_tready is low.
// arst_n clears both valid bits and sets all three config enables.
module misaligned_access_decode_align (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// instruction[31:0], trap_is_store[32], fp_state_on[33], load_bytes[97:34],
	// store_source[161:98], zero pad[167:162]
	input  logic [mada_pkg::IN_W-1:0]        s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// verdict[0], access_is_store[1], access_is_fp[2], access_len[6:3], reg_index[11:7],
	// instr_bytes[14:12], load_result[78:15], load_writeback[79], store_data[143:80],
	// set_fs_dirty[144], zero pad[151:145]
	output logic [mada_pkg::OUT_W-1:0]       m_tdata,
	input  logic                             cfg_we,
	input  logic [mada_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [0:0]                       cfg_data
);

	mada_pkg::mada_cfg_t cfg_q;

	logic                             valid_s1;
	logic [mada_pkg::IN_USED_W-1:0]   word_s1;
	logic                             valid_s2;
	mada_pkg::mada_res_t              res_s2;

	logic                s1_ready;
	logic                s2_ready;
	mada_pkg::mada_dec_t dec;
	mada_pkg::mada_res_t res;

	// Config writes must arrive only while the pipeline is empty; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{xlen_is_64: 1'b1, f_present: 1'b1, d_present: 1'b1};
		end else if (cfg_we) begin
			unique case (cfg_index)
				mada_pkg::CFG_XLEN_IS_64: cfg_q.xlen_is_64 <= cfg_data[0];
				mada_pkg::CFG_F_PRESENT:  cfg_q.f_present  <= cfg_data[0];
				mada_pkg::CFG_D_PRESENT:  cfg_q.d_present  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign s2_ready = ~valid_s2 | m_tready;
	assign s1_ready = ~valid_s1 | s2_ready;
	assign s_tready = s1_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s1_ready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s1_ready)
			word_s1 <= s_tdata[mada_pkg::IN_USED_W-1:0];
	end

	mada_decode u_decode (
		.instruction   (word_s1[mada_pkg::IN_INSTR_LSB +: 32]),
		.trap_is_store (word_s1[mada_pkg::IN_TST_BIT]),
		.fp_state_on   (word_s1[mada_pkg::IN_FSON_BIT]),
		.cfg           (cfg_q),
		.dec           (dec)
	);

	mada_align u_align (
		.dec          (dec),
		.xlen_is_64   (cfg_q.xlen_is_64),
		.load_bytes   (word_s1[mada_pkg::IN_LB_LSB +: 64]),
		.store_source (word_s1[mada_pkg::IN_SRC_LSB +: 64]),
		.res          (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s2_ready)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s2_ready)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;

	always_comb begin
		m_tdata = '0;
		m_tdata[mada_pkg::OUT_VERDICT_BIT]   = res_s2.verdict;
		m_tdata[mada_pkg::OUT_ST_BIT]        = res_s2.access_is_store;
		m_tdata[mada_pkg::OUT_FP_BIT]        = res_s2.access_is_fp;
		m_tdata[mada_pkg::OUT_LEN_LSB +: 4]  = res_s2.access_len;
		m_tdata[mada_pkg::OUT_REG_LSB +: 5]  = res_s2.reg_index;
		m_tdata[mada_pkg::OUT_ILEN_LSB +: 3] = res_s2.instr_bytes;
		m_tdata[mada_pkg::OUT_LRES_LSB +: 64] = res_s2.load_result;
		m_tdata[mada_pkg::OUT_WB_BIT]        = res_s2.load_writeback;
		m_tdata[mada_pkg::OUT_SDAT_LSB +: 64] = res_s2.store_data;
		m_tdata[mada_pkg::OUT_FSD_BIT]       = res_s2.set_fs_dirty;
	end

endmodule

/* hw/rtl/mada_check.sv */
// Port-level checker for the misaligned access decode block, with its bind.
module mada_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [mada_pkg::OUT_W-1:0]  m_tdata
);

	logic       verdict;
	logic       is_st;
	logic [3:0] len;
	logic [2:0] ilen;

	assign verdict = m_tdata[mada_pkg::OUT_VERDICT_BIT];
	assign is_st   = m_tdata[mada_pkg::OUT_ST_BIT];
	assign len     = m_tdata[mada_pkg::OUT_LEN_LSB +: 4];
	assign ilen    = m_tdata[mada_pkg::OUT_ILEN_LSB +: 3];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	a_redirect_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && verdict |-> m_tdata[mada_pkg::OUT_W-1:1] == '0)
		else $error("redirect word carries nonzero fields");

	a_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !verdict |->
			(ilen == 3'd2 || ilen == 3'd4) && (len == 4'd2 || len == 4'd4 || len == 4'd8))
		else $error("emulated access with bad length");

	a_store_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !verdict && is_st |->
			m_tdata[mada_pkg::OUT_LRES_LSB +: 64] == 64'd0 &&
			!m_tdata[mada_pkg::OUT_WB_BIT] && !m_tdata[mada_pkg::OUT_FSD_BIT])
		else $error("store word carries load results");

endmodule

bind misaligned_access_decode_align mada_check u_mada_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
